>>> hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int PHASE_COUNT_WIDTH_DEF = 16;
    localparam int PHASE_TICKS_W         = 16;
    localparam int ACK_LIMIT_W           = 8;
    localparam int BYTE_W                = 8;
    localparam int BIT_IDX_W             = 4;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [ACK_LIMIT_W-1:0]   ACK_LIMIT_RST   = 8'd250;
    localparam logic [BIT_IDX_W-1:0]     BITS_PER_BYTE   = 4'd8;

    typedef enum logic [0:0] {
        REG_PHASE_TICKS = 1'b0,
        REG_ACK_LIMIT   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_START_A  = 4'd1,
        ST_START_B  = 4'd2,
        ST_STOP_A   = 4'd3,
        ST_STOP_B   = 4'd4,
        ST_STOP_C   = 4'd5,
        ST_WR_LOW   = 4'd6,
        ST_WR_HIGH  = 4'd7,
        ST_ACK_A    = 4'd8,
        ST_ACK_B    = 4'd9,
        ST_ACK_POLL = 4'd10,
        ST_RD_LOW   = 4'd11,
        ST_RD_HIGH  = 4'd12,
        ST_RD_ACK_A = 4'd13,
        ST_RD_ACK_B = 4'd14
    } state_t;

    typedef struct packed {
        logic              cmd_valid;
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] write_byte;
        logic              send_ack;
        logic              sda_in;
    } tick_in_t;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_failed;
    } tick_out_t;

    typedef struct packed {
        logic [PHASE_TICKS_W-1:0] phase_ticks;
        logic [ACK_LIMIT_W-1:0]   ack_wait_limit;
    } cfg_t;

endpackage

>>> hw/rtl/i2cms_seq.sv
// ----------------------------------------------------------------------------
// i2cms_seq
// Bus phase sequencer: advances one tick per accepted transfer.
// ----------------------------------------------------------------------------
module i2cms_seq #(
    parameter int PHASE_COUNT_WIDTH = i2cms_pkg::PHASE_COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  i2cms_pkg::cfg_t      cfg,
    input  i2cms_pkg::tick_in_t  tick_in,
    output i2cms_pkg::tick_out_t tick_out
);

    localparam int W  = PHASE_COUNT_WIDTH;
    localparam int BW = i2cms_pkg::BYTE_W;
    localparam int IW = i2cms_pkg::BIT_IDX_W;
    localparam int LW = i2cms_pkg::ACK_LIMIT_W;

    i2cms_pkg::state_t state_reg, state_next;
    logic [W-1:0]  tick_reg, tick_next;
    logic [IW-1:0] bit_reg, bit_next;
    logic [BW-1:0] shift_reg, shift_next;
    logic [LW-1:0] poll_reg, poll_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic          ackc_reg, ackc_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;
    logic [BW-1:0] rdata_reg, rdata_next;
    logic          fail_reg, fail_next;
    logic          done;

    logic [i2cms_pkg::PHASE_TICKS_W-1:0] last_raw;
    logic [W-1:0]  last;
    logic          over;
    logic [W-1:0]  tick_adv;
    logic [IW-1:0] bit_inc;
    logic [BW-1:0] shift_sl;
    logic [LW:0]   poll_inc;

    assign last_raw = (cfg.phase_ticks == '0) ? '0 : cfg.phase_ticks - 1'b1;
    assign last     = W'(last_raw);
    assign over     = (tick_reg == last);
    assign tick_adv = over ? '0 : tick_reg + 1'b1;
    assign bit_inc  = bit_reg + 1'b1;
    assign shift_sl = {shift_reg[BW-2:0], 1'b0};
    assign poll_inc = {1'b0, poll_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cms_pkg::ST_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            poll_reg  <= '0;
            cmd_reg   <= '0;
            ackc_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rdata_reg <= '0;
            fail_reg  <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            cmd_reg   <= cmd_next;
            ackc_reg  <= ackc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rdata_reg <= rdata_next;
            fail_reg  <= fail_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        cmd_next   = cmd_reg;
        ackc_next  = ackc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rdata_next = rdata_reg;
        fail_next  = fail_reg;
        done       = 1'b0;

        unique case (state_reg)
            i2cms_pkg::ST_START_A: begin
                tick_next = tick_adv;
                if (over) begin
                    sda_next   = 1'b0;
                    state_next = i2cms_pkg::ST_START_B;
                end
            end
            i2cms_pkg::ST_START_B: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b0;
                    state_next = i2cms_pkg::ST_IDLE;
                    done       = 1'b1;
                end
            end
            i2cms_pkg::ST_STOP_A: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b1;
                    state_next = i2cms_pkg::ST_STOP_B;
                end
            end
            i2cms_pkg::ST_STOP_B: begin
                tick_next = tick_adv;
                if (over) begin
                    sda_next   = 1'b1;
                    state_next = i2cms_pkg::ST_STOP_C;
                end
            end
            i2cms_pkg::ST_STOP_C: begin
                tick_next = tick_adv;
                if (over) begin
                    if (cmd_reg == i2cms_pkg::REQ_WRITE) begin
                        fail_next = 1'b1;
                    end
                    state_next = i2cms_pkg::ST_IDLE;
                    done       = 1'b1;
                end
            end
            i2cms_pkg::ST_WR_LOW: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b1;
                    state_next = i2cms_pkg::ST_WR_HIGH;
                end
            end
            i2cms_pkg::ST_WR_HIGH: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b0;
                    shift_next = shift_sl;
                    bit_next   = bit_inc;
                    if (bit_inc < i2cms_pkg::BITS_PER_BYTE) begin
                        sda_next   = shift_sl[BW-1];
                        state_next = i2cms_pkg::ST_WR_LOW;
                    end else begin
                        sda_next   = 1'b1;
                        state_next = i2cms_pkg::ST_ACK_A;
                    end
                end
            end
            i2cms_pkg::ST_ACK_A: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b1;
                    state_next = i2cms_pkg::ST_ACK_B;
                end
            end
            i2cms_pkg::ST_ACK_B: begin
                tick_next = tick_adv;
                if (over) begin
                    poll_next  = '0;
                    state_next = i2cms_pkg::ST_ACK_POLL;
                end
            end
            i2cms_pkg::ST_ACK_POLL: begin
                if (!tick_in.sda_in) begin
                    scl_next   = 1'b0;
                    fail_next  = 1'b0;
                    state_next = i2cms_pkg::ST_IDLE;
                    done       = 1'b1;
                end else if (poll_inc > {1'b0, cfg.ack_wait_limit}) begin
                    sda_next   = 1'b0;
                    scl_next   = 1'b0;
                    tick_next  = '0;
                    state_next = i2cms_pkg::ST_STOP_A;
                end else begin
                    poll_next = poll_inc[LW-1:0];
                end
            end
            i2cms_pkg::ST_RD_LOW: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[BW-2:0], tick_in.sda_in};
                    state_next = i2cms_pkg::ST_RD_HIGH;
                end
            end
            i2cms_pkg::ST_RD_HIGH: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next = 1'b0;
                    bit_next = bit_inc;
                    if (bit_inc < i2cms_pkg::BITS_PER_BYTE) begin
                        state_next = i2cms_pkg::ST_RD_LOW;
                    end else begin
                        sda_next   = ~ackc_reg;
                        state_next = i2cms_pkg::ST_RD_ACK_A;
                    end
                end
            end
            i2cms_pkg::ST_RD_ACK_A: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b1;
                    state_next = i2cms_pkg::ST_RD_ACK_B;
                end
            end
            i2cms_pkg::ST_RD_ACK_B: begin
                tick_next = tick_adv;
                if (over) begin
                    scl_next   = 1'b0;
                    rdata_next = shift_reg;
                    state_next = i2cms_pkg::ST_IDLE;
                    done       = 1'b1;
                end
            end
            default: begin
                state_next = i2cms_pkg::ST_IDLE;
                if (tick_in.cmd_valid) begin
                    cmd_next  = tick_in.req_type;
                    bit_next  = '0;
                    tick_next = '0;
                    case (tick_in.req_type)
                        i2cms_pkg::REQ_START: begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            state_next = i2cms_pkg::ST_START_A;
                        end
                        i2cms_pkg::REQ_STOP: begin
                            sda_next   = 1'b0;
                            scl_next   = 1'b0;
                            state_next = i2cms_pkg::ST_STOP_A;
                        end
                        i2cms_pkg::REQ_WRITE: begin
                            shift_next = tick_in.write_byte;
                            sda_next   = tick_in.write_byte[BW-1];
                            state_next = i2cms_pkg::ST_WR_LOW;
                        end
                        default: begin
                            ackc_next  = tick_in.send_ack;
                            shift_next = '0;
                            sda_next   = 1'b1;
                            scl_next   = 1'b0;
                            state_next = i2cms_pkg::ST_RD_LOW;
                        end
                    endcase
                end
            end
        endcase
    end

    assign tick_out.scl_out    = scl_next;
    assign tick_out.sda_out    = sda_next;
    assign tick_out.busy_res   = (state_next != i2cms_pkg::ST_IDLE);
    assign tick_out.done_res   = done;
    assign tick_out.read_data  = rdata_next;
    assign tick_out.ack_failed = fail_next;

endmodule

>>> hw/rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master byte controller stepped one bus tick per input transfer.
// ----------------------------------------------------------------------------
//   channel   | direction | handshake               | contents
//   s_        | in        | s_tvalid / s_tready     | one tick: command, SDA sample
//   m_        | out       | m_tvalid / m_tready     | line drives and status
//   APB       | in        | psel & penable & pwrite | phase_ticks, ack_wait_limit
//
// One transfer per cycle while s_tready is high; its result is registered and shows the next cycle.
// The result is taken from the phase sequencer's single next-state pass.
// s_tready is high while the output register is empty or being taken.
// Reset is synchronous on aresetn; no clearing pass.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
    parameter int PHASE_COUNT_WIDTH = i2cms_pkg::PHASE_COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // write_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
    input  logic [i2cms_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd_valid[0], req_type[2:1]
    input  logic [i2cms_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
    // ack_failed[12], zero[15:13]
    output logic [i2cms_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [i2cms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [i2cms_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int DW = i2cms_pkg::APB_DATA_W;

    i2cms_pkg::cfg_t      cfg_reg;
    i2cms_pkg::tick_in_t  tick_in;
    i2cms_pkg::tick_out_t tick_out;
    i2cms_pkg::reg_idx_t  reg_sel;
    logic                 in_xfer;
    logic                 cfg_wr;
    logic                 m_valid_reg, m_valid_next;
    logic [i2cms_pkg::M_TDATA_W-1:0] m_data_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_sel = i2cms_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks    <= i2cms_pkg::PHASE_TICKS_RST;
            cfg_reg.ack_wait_limit <= i2cms_pkg::ACK_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                i2cms_pkg::REG_PHASE_TICKS: begin
                    cfg_reg.phase_ticks <= pwdata[i2cms_pkg::PHASE_TICKS_W-1:0];
                end
                default: begin
                    cfg_reg.ack_wait_limit <= pwdata[i2cms_pkg::ACK_LIMIT_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            i2cms_pkg::REG_PHASE_TICKS: prdata = DW'(cfg_reg.phase_ticks);
            default:                    prdata = DW'(cfg_reg.ack_wait_limit);
        endcase
    end

    assign s_tready = ~m_valid_reg | m_tready;
    assign in_xfer  = s_tvalid & s_tready;

    assign tick_in.cmd_valid  = s_tuser[0];
    assign tick_in.req_type   = s_tuser[2:1];
    assign tick_in.write_byte = s_tdata[7:0];
    assign tick_in.send_ack   = s_tdata[8];
    assign tick_in.sda_in     = s_tdata[9];

    i2cms_seq #(
        .PHASE_COUNT_WIDTH(PHASE_COUNT_WIDTH)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_xfer),
        .cfg     (cfg_reg),
        .tick_in (tick_in),
        .tick_out(tick_out)
    );

    always_comb begin
        if (in_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= {3'b000, tick_out.ack_failed, tick_out.read_data,
                           tick_out.done_res, tick_out.busy_res,
                           tick_out.sda_out, tick_out.scl_out};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hw/rtl/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [i2cms_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy both set");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_xfer_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("transfer produced no result");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .pready  (pready)
);
